// ----- src/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned POS_OUT_W = 11;
  localparam int unsigned CELL_W    = 16;
  // linear address width that covers the largest screen, 32 x 128
  localparam int unsigned POS_W     = 12;
  // tab phase, col mod tab stop, tab stop at most 8
  localparam int unsigned TAB_W     = 3;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_LF,
    OP_CR,
    OP_SET,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_RDWAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [TAB_W-1:0]  phase;
    logic [POS_W-1:0]  addr;
    logic              hit;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [POS_OUT_W-1:0] pos;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
  } res_t;

  function automatic logic [CELL_W-1:0] blank(input logic [ATTR_W-1:0] attr);
    return {attr, CH_SPACE};
  endfunction

endpackage

`default_nettype wire

// ----- src/tcc_front.sv -----
// ----------------------------------------------------------------------------
// tcc_front
// Request decode: classifies each request, computes the target cell address,
// range check and tab phase, and holds the result in one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_front #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [tcc_pkg::REQ_W-1:0]   in_req_i,
  input  wire logic [tcc_pkg::CHAR_W-1:0]  in_char_i,
  input  wire logic [tcc_pkg::ATTR_W-1:0]  in_attr_i,
  input  wire logic [tcc_pkg::ROW_W-1:0]   in_row_i,
  input  wire logic [tcc_pkg::COL_W-1:0]   in_col_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tcc_pkg::cmd_t                    out_cmd_o
);

  localparam int unsigned COL_N = 2 ** tcc_pkg::COL_W;

  logic [tcc_pkg::TAB_W-1:0] rem_tbl [COL_N];
  tcc_pkg::cmd_t             cmd_d, cmd_q;
  logic                      valid_q;
  logic                      load;

  for (genvar g = 0; g < COL_N; g++) begin : g_rem
    assign rem_tbl[g] = tcc_pkg::TAB_W'(g % TAB_STOP);
  end

  always_comb begin
    cmd_d       = '0;
    cmd_d.attr  = in_attr_i;
    cmd_d.chr   = in_char_i;
    cmd_d.row   = in_row_i;
    cmd_d.col   = in_col_i;
    cmd_d.phase = rem_tbl[in_col_i];
    cmd_d.hit   = (int'(in_row_i) < ROWS) && (int'(in_col_i) < COLUMNS);
    cmd_d.addr  = tcc_pkg::POS_W'(in_row_i) * tcc_pkg::POS_W'(COLUMNS)
                + tcc_pkg::POS_W'(in_col_i);
    unique case (tcc_pkg::req_e'(in_req_i))
      tcc_pkg::REQ_PUT: begin
        unique case (in_char_i)
          tcc_pkg::CH_BS:  cmd_d.op = tcc_pkg::OP_BS;
          tcc_pkg::CH_TAB: cmd_d.op = tcc_pkg::OP_TAB;
          tcc_pkg::CH_LF:  cmd_d.op = tcc_pkg::OP_LF;
          tcc_pkg::CH_CR:  cmd_d.op = tcc_pkg::OP_CR;
          default:         cmd_d.op = tcc_pkg::OP_PRINT;
        endcase
      end
      tcc_pkg::REQ_SET:   cmd_d.op = tcc_pkg::OP_SET;
      tcc_pkg::REQ_CLEAR: cmd_d.op = tcc_pkg::OP_CLEAR;
      tcc_pkg::REQ_READ:  cmd_d.op = tcc_pkg::OP_READ;
      default:            cmd_d.op = tcc_pkg::OP_READ;
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_cmd_o   = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/tcc_queue.sv -----
// ----------------------------------------------------------------------------
// tcc_queue
// Small command FIFO between decode and the cell sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_valid_i,
  output logic         push_ready_o,
  input  wire tcc_pkg::cmd_t push_cmd_i,
  output logic         pop_valid_o,
  input  wire logic    pop_ready_i,
  output tcc_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tcc_pkg::cmd_t    store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = store[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/tcc_back.sv -----
// ----------------------------------------------------------------------------
// tcc_back
// Cell sequencer: owns the screen memory and the cursor, executes commands,
// runs the scroll, clear and post-reset sweeps, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_back #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tcc_pkg::ATTR_W-1:0]  cfg_data_i,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_ready_o,
  input  wire tcc_pkg::cmd_t               cmd_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output tcc_pkg::res_t                    res_o
);

  localparam int unsigned CELLS        = ROWS * COLUMNS;
  localparam int unsigned AW           = $clog2(CELLS);
  localparam int unsigned PW           = (AW > tcc_pkg::POS_OUT_W) ? AW : tcc_pkg::POS_OUT_W;
  localparam int unsigned LAST_ROW_POS = (ROWS - 1) * COLUMNS;
  localparam int unsigned CW1          = tcc_pkg::COL_W + 1;

  logic [tcc_pkg::CELL_W-1:0] mem [CELLS];

  tcc_pkg::state_e             state_q, state_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [tcc_pkg::ROW_W-1:0]   row_q, n_row;
  logic [tcc_pkg::COL_W-1:0]   col_q, n_col;
  logic [AW-1:0]               pos_q, n_pos;
  logic [tcc_pkg::TAB_W-1:0]   phase_q, n_phase;
  logic [tcc_pkg::ATTR_W-1:0]  attr_q, reset_attr_q;
  logic [tcc_pkg::CELL_W-1:0]  rdata_q;
  logic                        rd_hit_q;
  logic                        res_valid_q;
  tcc_pkg::res_t               res_q, res_d;

  logic                        out_free, go, idx_last, need_scroll, long_op, res_load;
  logic                        at_last_row, last_col;
  logic [CW1-1:0]              tab_col;
  logic [AW-1:0]               nl_pos;
  logic                        put_we;
  logic [AW-1:0]               put_addr;
  logic [tcc_pkg::CELL_W-1:0]  put_data;
  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [tcc_pkg::CELL_W-1:0]  wdata;
  logic [PW-1:0]               pos_ext;

  assign out_free    = !res_valid_q || res_ready_i;
  assign go          = (state_q == tcc_pkg::ST_IDLE) && cmd_valid_i && out_free;
  assign cmd_ready_o = go;
  assign idx_last    = idx_q == AW'(CELLS - 1);
  assign cfg_ready_o = state_q != tcc_pkg::ST_INIT;
  assign at_last_row = row_q == tcc_pkg::ROW_W'(ROWS - 1);
  assign last_col    = col_q == tcc_pkg::COL_W'(COLUMNS - 1);
  assign tab_col     = CW1'(col_q) - CW1'(phase_q) + CW1'(TAB_STOP);
  assign nl_pos      = pos_q - AW'(col_q) + AW'(COLUMNS);
  assign long_op     = need_scroll || (cmd_i.op == tcc_pkg::OP_CLEAR)
                    || (cmd_i.op == tcc_pkg::OP_READ);

  // cursor update for the command at the head of the queue
  always_comb begin
    n_row       = row_q;
    n_col       = col_q;
    n_pos       = pos_q;
    n_phase     = phase_q;
    need_scroll = 1'b0;
    put_we      = 1'b0;
    put_addr    = pos_q;
    put_data    = tcc_pkg::blank(cmd_i.attr);
    unique case (cmd_i.op)
      tcc_pkg::OP_PRINT: begin
        put_we   = 1'b1;
        put_data = {cmd_i.attr, cmd_i.chr};
        if (last_col) begin
          need_scroll = at_last_row;
          n_row       = row_q + 1'b1;
          n_col       = '0;
          n_pos       = pos_q + 1'b1;
          n_phase     = '0;
        end else begin
          n_col   = col_q + 1'b1;
          n_pos   = pos_q + 1'b1;
          n_phase = (phase_q == tcc_pkg::TAB_W'(TAB_STOP - 1)) ? '0 : phase_q + 1'b1;
        end
      end
      tcc_pkg::OP_LF: begin
        need_scroll = at_last_row;
        n_row       = row_q + 1'b1;
        n_col       = '0;
        n_pos       = nl_pos;
        n_phase     = '0;
      end
      tcc_pkg::OP_CR: begin
        n_col   = '0;
        n_pos   = pos_q - AW'(col_q);
        n_phase = '0;
      end
      tcc_pkg::OP_TAB: begin
        n_phase = '0;
        if (tab_col >= CW1'(COLUMNS)) begin
          need_scroll = at_last_row;
          n_row       = row_q + 1'b1;
          n_col       = '0;
          n_pos       = nl_pos;
        end else begin
          n_col = tab_col[tcc_pkg::COL_W-1:0];
          n_pos = pos_q - AW'(phase_q) + AW'(TAB_STOP);
        end
      end
      tcc_pkg::OP_BS: begin
        if (col_q != '0) begin
          put_we   = 1'b1;
          put_addr = pos_q - 1'b1;
          n_col    = col_q - 1'b1;
          n_pos    = pos_q - 1'b1;
          n_phase  = (phase_q == '0) ? tcc_pkg::TAB_W'(TAB_STOP - 1) : phase_q - 1'b1;
        end else if (row_q != '0) begin
          n_row   = row_q - 1'b1;
          n_col   = tcc_pkg::COL_W'(COLUMNS - 1);
          n_pos   = pos_q - 1'b1;
          n_phase = tcc_pkg::TAB_W'((COLUMNS - 1) % TAB_STOP);
        end
      end
      tcc_pkg::OP_SET: begin
        if (cmd_i.hit) begin
          n_row   = cmd_i.row;
          n_col   = cmd_i.col;
          n_pos   = AW'(cmd_i.addr);
          n_phase = cmd_i.phase;
        end
      end
      tcc_pkg::OP_CLEAR: begin
        n_row   = '0;
        n_col   = '0;
        n_pos   = '0;
        n_phase = '0;
      end
      tcc_pkg::OP_READ: begin
      end
    endcase
    if (need_scroll) begin
      n_row   = tcc_pkg::ROW_W'(ROWS - 1);
      n_col   = '0;
      n_pos   = AW'(LAST_ROW_POS);
      n_phase = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcc_pkg::ST_INIT: begin
        if (idx_last) state_d = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_IDLE: begin
        if (go) begin
          if (cmd_i.op == tcc_pkg::OP_CLEAR) begin
            state_d = tcc_pkg::ST_CLEAR;
          end else if (cmd_i.op == tcc_pkg::OP_READ) begin
            state_d = tcc_pkg::ST_RDWAIT;
          end else if (need_scroll) begin
            state_d = tcc_pkg::ST_SCROLL;
          end
        end
      end
      tcc_pkg::ST_SCROLL,
      tcc_pkg::ST_CLEAR: begin
        if (idx_last) state_d = tcc_pkg::ST_FINISH;
      end
      tcc_pkg::ST_RDWAIT,
      tcc_pkg::ST_FINISH: begin
        if (out_free) state_d = tcc_pkg::ST_IDLE;
      end
      default: state_d = tcc_pkg::ST_INIT;
    endcase
  end

  // memory port control and sweep index
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = tcc_pkg::blank(attr_q);
    re    = 1'b0;
    raddr = AW'(COLUMNS);
    idx_d = '0;
    unique case (state_q)
      tcc_pkg::ST_INIT: begin
        we    = 1'b1;
        wdata = tcc_pkg::blank(reset_attr_q);
        idx_d = idx_last ? '0 : idx_q + 1'b1;
      end
      tcc_pkg::ST_IDLE: begin
        if (go) begin
          we    = put_we;
          waddr = put_addr;
          wdata = put_data;
          if (need_scroll) begin
            re = 1'b1;
          end
          if (cmd_i.op == tcc_pkg::OP_READ) begin
            re    = cmd_i.hit;
            raddr = AW'(cmd_i.addr);
          end
        end
      end
      tcc_pkg::ST_SCROLL: begin
        we = 1'b1;
        if (idx_q < AW'(CELLS - COLUMNS)) begin
          wdata = rdata_q;
        end
        re    = idx_q < AW'(CELLS - COLUMNS - 1);
        raddr = idx_q + AW'(COLUMNS + 1);
        idx_d = idx_last ? '0 : idx_q + 1'b1;
      end
      tcc_pkg::ST_CLEAR: begin
        we    = 1'b1;
        idx_d = idx_last ? '0 : idx_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    res_load = 1'b0;
    pos_ext  = PW'(n_pos);
    res_d    = '0;
    res_d.row = n_row;
    res_d.col = n_col;
    if (state_q == tcc_pkg::ST_IDLE) begin
      res_load = go && !long_op;
    end else begin
      pos_ext   = PW'(pos_q);
      res_d.row = row_q;
      res_d.col = col_q;
      if (state_q == tcc_pkg::ST_RDWAIT) begin
        res_load        = out_free;
        res_d.cell_data = rd_hit_q ? rdata_q : '0;
      end else if (state_q == tcc_pkg::ST_FINISH) begin
        res_load = out_free;
      end
    end
    res_d.pos = pos_ext[tcc_pkg::POS_OUT_W-1:0];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tcc_pkg::ST_INIT;
      idx_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      pos_q        <= '0;
      phase_q      <= '0;
      res_valid_q  <= 1'b0;
      reset_attr_q <= tcc_pkg::RESET_ATTR;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (go) begin
        row_q   <= n_row;
        col_q   <= n_col;
        pos_q   <= n_pos;
        phase_q <= n_phase;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        reset_attr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      attr_q   <= cmd_i.attr;
      rd_hit_q <= cmd_i.hit;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < COLUMNS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < ROWS)
    else $error("cursor row out of range");

  a_pos_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pos_q) == int'(row_q) * COLUMNS + int'(col_q))
    else $error("linear position out of step with row and column");

  a_tab_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(phase_q) == int'(col_q) % TAB_STOP)
    else $error("tab phase out of step with column");

endmodule

`default_nettype wire

// ----- src/text_console_cursor_engine_core.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Text console with cursor: put char, set cursor, clear and read requests on
// a stream interface, one result word per request.
// ----------------------------------------------------------------------------
// Requests are decoded into a register stage, pass a short queue and are
// executed by a sequencer that owns the ROWS x COLUMNS cell memory (one write
// and one registered read port). Printable characters, return, newline, tab,
// backspace and set cursor that do not scroll complete without leaving the
// idle state, so they stream at one request per clock while the output is
// not stalled. A read cell passes through a read wait state. A put that runs
// off the bottom row scrolls the screen and holds the sequencer for a sweep
// of the whole memory; clear screen holds it for the same sweep. After reset
// the memory is swept to blanks before the first request executes; the
// config channel is held off during that sweep, and the register only sets
// the attribute of that post-reset fill. Results leave through an output
// register.
`default_nettype none

module text_console_cursor_engine_core #(
  parameter int unsigned COLUMNS     = 80,
  parameter int unsigned ROWS        = 25,
  parameter int unsigned TAB_STOP    = 4,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // char_code[7:0], attribute[15:8], target_row[20:16], target_col[27:21]
  input  wire logic [31:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cursor_row_out[4:0], cursor_col_out[11:5], cursor_position[22:12],
  // cell_data[38:23]
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);

  logic          fr_valid, fr_ready;
  tcc_pkg::cmd_t fr_cmd;
  logic          q_valid, q_ready;
  tcc_pkg::cmd_t q_cmd;
  tcc_pkg::res_t res;

  tcc_front #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (s_axis_tuser),
    .in_char_i   (s_axis_tdata[7:0]),
    .in_attr_i   (s_axis_tdata[15:8]),
    .in_row_i    (s_axis_tdata[20:16]),
    .in_col_i    (s_axis_tdata[27:21]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_cmd_o   (fr_cmd)
  );

  tcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  tcc_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.cell_data, res.pos, res.col, res.row};

endmodule

`default_nettype wire

// ----- test/text_console_cursor_engine_core_test.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core_test
// Stream test of the text console: a shadow screen and cursor predict every
// result word; directed corner cases, then random request mixes with text
// runs, under changing source and sink stalls and reset attribute writes.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_COLS  = 80;
  localparam int NUM_ROWS  = 25;
  localparam int TAB_WIDTH = 4;
  localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;

  typedef struct {
    tcc_pkg::req_e req;
    logic [7:0]    chr;
    logic [7:0]    attr;
    logic [4:0]    row;
    logic [6:0]    col;
  } console_req_t;

  typedef struct {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] pos;
    logic [15:0] cell_data;
  } cursor_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;

  console_req_t pending_reqs[$];
  cursor_word_t predicted_words[$];
  logic [15:0]  shadow_screen[NUM_CELLS];
  int           shadow_row;
  int           shadow_col;
  logic [7:0]   shadow_reset_attr;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           errors      = 0;

  text_console_cursor_engine_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void fill_shadow(input logic [7:0] attr);
    for (int i = 0; i < NUM_CELLS; i++) shadow_screen[i] = {attr, tcc_pkg::CH_SPACE};
  endfunction

  function automatic cursor_word_t console_apply(input console_req_t r);
    int           row;
    int           col;
    int           lin;
    cursor_word_t w;
    w.cell_data = '0;
    row = shadow_row;
    col = shadow_col;
    case (r.req)
      tcc_pkg::REQ_PUT: begin
        if (r.chr == tcc_pkg::CH_LF) begin
          col = 0;
          row++;
        end else if (r.chr == tcc_pkg::CH_CR) begin
          col = 0;
        end else if (r.chr == tcc_pkg::CH_TAB) begin
          col = col - (col % TAB_WIDTH) + TAB_WIDTH;
        end else if (r.chr == tcc_pkg::CH_BS) begin
          if (col > 0) begin
            col--;
            shadow_screen[row * NUM_COLS + col] = {r.attr, tcc_pkg::CH_SPACE};
          end else if (row > 0) begin
            row--;
            col = NUM_COLS - 1;
          end
        end else begin
          shadow_screen[row * NUM_COLS + col] = {r.attr, r.chr};
          col++;
        end
        if (col >= NUM_COLS) begin
          col = 0;
          row++;
        end
        if (row >= NUM_ROWS) begin
          for (int i = 0; i + NUM_COLS < NUM_CELLS; i++)
            shadow_screen[i] = shadow_screen[i + NUM_COLS];
          for (int i = (NUM_ROWS - 1) * NUM_COLS; i < NUM_CELLS; i++)
            shadow_screen[i] = {r.attr, tcc_pkg::CH_SPACE};
          row = NUM_ROWS - 1;
          col = 0;
        end
        shadow_row = row;
        shadow_col = col;
      end
      tcc_pkg::REQ_SET: begin
        if (r.row < NUM_ROWS && r.col < NUM_COLS) begin
          shadow_row = r.row;
          shadow_col = r.col;
        end
      end
      tcc_pkg::REQ_CLEAR: begin
        fill_shadow(r.attr);
        shadow_row = 0;
        shadow_col = 0;
      end
      default: begin
        if (r.row < NUM_ROWS && r.col < NUM_COLS)
          w.cell_data = shadow_screen[r.row * NUM_COLS + r.col];
      end
    endcase
    lin   = shadow_row * NUM_COLS + shadow_col;
    w.row = shadow_row[4:0];
    w.col = shadow_col[6:0];
    w.pos = lin[10:0];
    return w;
  endfunction

  // source side
  always @(posedge clk_i) begin
    bit show;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predicted_words.push_back(console_apply(pending_reqs.pop_front()));
      show = (s_axis_tvalid && !s_axis_tready) ||
             (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct);
      if (show) begin
        s_axis_tdata <= {4'b0, pending_reqs[0].col, pending_reqs[0].row,
                         pending_reqs[0].attr, pending_reqs[0].chr};
        s_axis_tuser <= pending_reqs[0].req;
      end
      s_axis_tvalid <= show;
    end
  end

  task automatic check_word(input logic [39:0] data);
    cursor_word_t want;
    if (predicted_words.size() == 0) begin
      note_mismatch($sformatf("result word 0x%010h with nothing pending", data));
    end else begin
      want = predicted_words.pop_front();
      if (data[4:0] !== want.row)
        note_mismatch($sformatf("cursor row got %0d want %0d", data[4:0], want.row));
      if (data[11:5] !== want.col)
        note_mismatch($sformatf("cursor col got %0d want %0d", data[11:5], want.col));
      if (data[22:12] !== want.pos)
        note_mismatch($sformatf("position got %0d want %0d", data[22:12], want.pos));
      if (data[38:23] !== want.cell_data)
        note_mismatch($sformatf("cell got 0x%04h want 0x%04h", data[38:23],
                                want.cell_data));
    end
  endtask

  // sink side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
      m_axis_tready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  function automatic console_req_t mk_req(input tcc_pkg::req_e req,
                                          input logic [7:0] chr,
                                          input logic [7:0] attr, input logic [4:0] row,
                                          input logic [6:0] col);
    console_req_t r;
    r.req  = req;
    r.chr  = chr;
    r.attr = attr;
    r.row  = row;
    r.col  = col;
    return r;
  endfunction

  function automatic console_req_t rand_req();
    console_req_t r;
    int           pick;
    r = mk_req(tcc_pkg::REQ_PUT, 8'($urandom), 8'($urandom), 5'($urandom),
               7'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      case ($urandom_range(0, 9))
        0: r.chr = tcc_pkg::CH_LF;
        1: r.chr = tcc_pkg::CH_CR;
        2: r.chr = tcc_pkg::CH_TAB;
        3: r.chr = tcc_pkg::CH_BS;
        default: ;
      endcase
    end else if (pick < 77) begin
      r.req = tcc_pkg::REQ_SET;
      if ($urandom_range(0, 4) != 0) begin
        r.row = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(22, 24))
                                            : 5'($urandom_range(0, 24));
        r.col = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(70, 79))
                                            : 7'($urandom_range(0, 79));
      end
    end else if (pick < 97) begin
      r.req = tcc_pkg::REQ_READ;
      if ($urandom_range(0, 9) < 7) begin
        r.row = 5'($urandom_range(0, 24));
        r.col = 7'($urandom_range(0, 79));
      end
    end else begin
      r.req = tcc_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  task automatic push_random(input int n);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(4, 40);
        for (int i = 0; i < len; i++)
          pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, 8'($urandom_range(32, 126)),
                                        8'($urandom), 5'($urandom), 7'($urandom)));
        cnt += len;
        if ($urandom_range(0, 1) == 0) begin
          pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_LF, 8'($urandom),
                                        5'($urandom), 7'($urandom)));
          cnt++;
        end
      end else begin
        pending_reqs.push_back(rand_req());
        cnt++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || predicted_words.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
  endtask

  task automatic write_reset_attr(input logic [7:0] v);
    @(posedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // only the post-reset sweep uses it, the screen stays as it is
    shadow_reset_attr = v;
  endtask

  task automatic set_idling(input int tx, input int rx);
    @(negedge clk_i);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  task automatic push_directed();
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_READ, 8'hFF, 8'hFF, 5'd24, 7'd79));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, 8'h41, 8'hFF, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, 8'h00, 8'h00, 5'd31, 7'd127));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, 8'hFF, 8'hA5, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_BS, 8'h12, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd2));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_CR, 8'h00, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_BS, 8'h55, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_TAB, 8'h00, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_SET, 8'h00, 8'h00, 5'd0, 7'd78));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_TAB, 8'h00, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_BS, 8'h66, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_SET, 8'h00, 8'h00, 5'd25, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_SET, 8'h00, 8'h00, 5'd0, 7'd80));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_SET, 8'hFF, 8'hFF, 5'd31, 7'd127));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_READ, 8'h00, 8'h00, 5'd31, 7'd127));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd80));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_SET, 8'h00, 8'h00, 5'd24, 7'd79));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, 8'h5A, 8'h1E, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_READ, 8'h00, 8'h00, 5'd23, 7'd79));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_LF, 8'hC3, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_SET, 8'h00, 8'h00, 5'd10, 7'd5));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_PUT, tcc_pkg::CH_LF, 8'h00, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_CLEAR, 8'h00, 8'h3C, 5'd0, 7'd0));
    pending_reqs.push_back(mk_req(tcc_pkg::REQ_READ, 8'h00, 8'h00, 5'd12, 7'd40));
  endtask

  initial begin
    shadow_reset_attr = tcc_pkg::RESET_ATTR;
    fill_shadow(shadow_reset_attr);
    shadow_row = 0;
    shadow_col = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reset_attr(8'hFF);
    set_idling(8, 72);
    push_directed();
    wait_drained();

    write_reset_attr(8'h00);
    set_idling(8, 72);
    push_random(500);
    wait_drained();

    write_reset_attr(8'($urandom));
    set_idling(72, 8);
    push_random(500);
    wait_drained();

    write_reset_attr(8'($urandom));
    set_idling(0, 0);
    push_random(525);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (errors == 0 && predicted_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

endmodule
